// ===== sv/swtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package swtm_pkg;
  localparam int CfgWidth = 7;
  localparam int CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] RegWindowSize = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegTrimCount = 1'b1;
  localparam int WinWidth = 7;
  localparam int TrimWidth = 5;
  localparam int AvgWidth = 16;

  typedef enum logic [2:0] {
    StIdle,
    StRemove,
    StInsert,
    StSum,
    StDiv,
    StOut
  } state_e;
endpackage
`default_nettype wire

// ===== sv/swtm_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtm_divider import swtm_pkg::*; #(
  parameter int NumWidth = 22,
  parameter int DenWidth = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [NumWidth-1:0] num_i,
  input  wire logic [DenWidth-1:0] den_i,
  output logic                     done_o,
  output logic [NumWidth-1:0]      quo_o
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] quo_q, quo_d;
  logic [DenWidth:0]   rem_q, rem_d;
  logic [DenWidth-1:0] den_q, den_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DenWidth:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenWidth-1:0], quo_q[NumWidth-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntWidth'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

// ===== sv/swtm_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtm_sorter import swtm_pkg::*; #(
  parameter int Depth = 64,
  parameter int SampleWidth = 16,
  parameter int CntWidth = 7
) (
  input  wire logic                   clk_i,
  input  wire logic                   remove_i,
  input  wire logic                   insert_i,
  input  wire logic [SampleWidth-1:0] value_i,
  input  wire logic [CntWidth-1:0]    count_i,
  output logic [SampleWidth-1:0]      cells_o [Depth]
);
  logic [SampleWidth-1:0] cell_q [Depth];
  logic [Depth-1:0] match, gt, found;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      match[i] = (CntWidth'(i) < count_i) && (cell_q[i] == value_i);
      gt[i]    = (CntWidth'(i) < count_i) && (cell_q[i] > value_i);
    end
    found[0] = match[0];
    for (int i = 1; i < Depth; i++) found[i] = found[i-1] | match[i];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (remove_i) begin
        if (found[i] && i + 1 < Depth) cell_q[i] <= cell_q[(i + 1) % Depth];
      end else if (insert_i) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i + Depth - 1) % Depth]) cell_q[i] <= cell_q[(i + Depth - 1) % Depth];
          else cell_q[i] <= value_i;
        end else if (i > 0 && (gt[(i + Depth - 1) % Depth] || CntWidth'(i) == count_i)
                     && !gt[i]) begin
          if (CntWidth'(i) <= count_i &&
              (CntWidth'(i) == count_i || !gt[i])) begin
            if (gt[(i + Depth - 1) % Depth]) cell_q[i] <= cell_q[(i + Depth - 1) % Depth];
            else cell_q[i] <= value_i;
          end
        end else if (i == 0 && count_i == '0) begin
          cell_q[i] <= value_i;
        end
      end
    end
  end

  assign cells_o = cell_q;
endmodule
`default_nettype wire

// ===== sv/sliding_window_trimmed_mean_core.sv =====
// Sliding-window trimmed mean core.
// Samples arrive on the s_axis channel, one 16-bit sample per beat.
// Each beat yields one result beat on m_axis carrying the average, a valid
// flag and a configuration error flag.
// The core handles one sample at a time: s_axis_tready is high only while
// idle with no result waiting.
// While the window fills, the sample passes through the insert and output states
// before the result beat is offered. With a full window and a sound configuration
// it passes through the remove and insert steps, the middle sum, added one sorted
// cell per cycle, and the 23-step shift-subtract divider.
// The beat that first fills the window skips the remove step. With a configuration
// error a full window skips the sum and the divider, and window_size 0 goes from
// idle straight to the output state.
// A new sample can be taken once the result beat has been delivered.
// Writing either configuration register empties the window.
// Reset empties the window and loads window_size 3 and trim_count 1.
// When the receiver stalls, the result waits in the output register and
// no new sample is taken until it is delivered.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_trimmed_mean_core import swtm_pkg::*; #(
  parameter int WINDOW_MAX = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [15:0]            s_axis_tdata,   // sample
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [23:0]                 m_axis_tdata,   // average, average_valid, config_error
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [CfgWidth-1:0]    cfg_data_i
);
  localparam int PtrWidth = $clog2(WINDOW_MAX);
  localparam int CntWidth = $clog2(WINDOW_MAX + 1);
  localparam int SumWidth = SAMPLE_WIDTH + CntWidth;

  state_e state_q, state_d;
  logic [WinWidth-1:0]  win_q;
  logic [TrimWidth-1:0] trim_q;
  logic [CntWidth-1:0]  fill_q, fill_d, m_eff, idx_q, idx_d;
  logic [PtrWidth-1:0]  ptr_q, ptr_d;
  logic [SumWidth-1:0]  sum_q, sum_d;
  logic [SAMPLE_WIDTH-1:0] samp_q, samp_d, old_q;
  logic [SAMPLE_WIDTH-1:0] ring_q [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cells [WINDOW_MAX];
  logic [AvgWidth-1:0] avg_q, avg_d;
  logic vld_q, vld_d, err_q, err_d, ovld_q, ovld_d;
  logic [WinWidth:0] twok;
  logic [CntWidth-1:0] hi_idx;
  logic [SumWidth-1:0] quo;
  logic div_start;
  logic div_done;

  assign m_eff = (int'(win_q) > WINDOW_MAX) ? CntWidth'(WINDOW_MAX)
               : CntWidth'(win_q);
  assign twok   = {2'b0, trim_q, 1'b0};
  assign hi_idx = m_eff - CntWidth'(trim_q);

  swtm_sorter #(.Depth(WINDOW_MAX), .SampleWidth(SAMPLE_WIDTH), .CntWidth(CntWidth))
    u_sorter (
    .clk_i, .remove_i(state_q == StRemove), .insert_i(state_q == StInsert),
    .value_i((state_q == StRemove) ? old_q : samp_q), .count_i(fill_q),
    .cells_o(cells)
  );

  swtm_divider #(.NumWidth(SumWidth), .DenWidth(WinWidth + 1)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_q),
    .den_i((WinWidth+1)'(m_eff) - twok), .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    state_d = state_q; fill_d = fill_q; ptr_d = ptr_q; sum_d = sum_q;
    idx_d = idx_q; samp_d = samp_q; avg_d = avg_q; vld_d = vld_q;
    err_d = err_q; ovld_d = ovld_q; div_start = 1'b0;
    s_axis_tready = (state_q == StIdle) && !ovld_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          samp_d = SAMPLE_WIDTH'(s_axis_tdata);
          err_d  = ({1'b0, twok} >= (WinWidth+2)'(m_eff));
          vld_d = 1'b0; avg_d = '0;
          if (m_eff == '0) state_d = StOut;
          else if (fill_q >= m_eff) begin
            if (CntWidth'(ptr_q) >= m_eff) ptr_d = '0;
            state_d = StRemove;
          end else state_d = StInsert;
        end
      end
      StRemove: begin
        fill_d = m_eff - 1'b1;
        ptr_d = (CntWidth'(ptr_q) + 1'b1 >= m_eff) ? '0 : ptr_q + 1'b1;
        state_d = StInsert;
      end
      StInsert: begin
        fill_d = fill_q + 1'b1;
        idx_d = CntWidth'(trim_q);
        sum_d = '0;
        state_d = (!err_q && fill_q + 1'b1 == m_eff) ? StSum : StOut;
      end
      StSum: begin
        if (idx_q < hi_idx) begin
          sum_d = sum_q + SumWidth'(cells[idx_q[PtrWidth-1:0]]);
          idx_d = idx_q + 1'b1;
        end else begin
          div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: if (div_done) begin
        avg_d = AvgWidth'(quo);
        vld_d = 1'b1;
        state_d = StOut;
      end
      StOut: if (!ovld_q) begin
        ovld_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i && (cfg_idx_i == RegWindowSize || cfg_idx_i == RegTrimCount)) begin
      fill_d = '0; ptr_d = '0; sum_d = '0;
    end
  end

  logic [PtrWidth-1:0] slot_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) old_q <= ring_q[ptr_d];
    if (state_q == StRemove) slot_q <= ptr_q;
    else if (state_q == StIdle) slot_q <= PtrWidth'(fill_q);
    if (state_q == StInsert) ring_q[slot_q] <= samp_q;
    samp_q <= samp_d; avg_q <= avg_d; vld_q <= vld_d; err_q <= err_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; fill_q <= '0; ptr_q <= '0; sum_q <= '0;
      ovld_q <= 1'b0; win_q <= WinWidth'(3); trim_q <= TrimWidth'(1);
    end else begin
      state_q <= state_d; fill_q <= fill_d; ptr_q <= ptr_d; sum_q <= sum_d;
      ovld_q <= ovld_d;
      if (cfg_we_i && cfg_idx_i == RegWindowSize) win_q <= cfg_data_i[WinWidth-1:0];
      if (cfg_we_i && cfg_idx_i == RegTrimCount) trim_q <= cfg_data_i[TrimWidth-1:0];
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'b0, err_q, vld_q, avg_q};
endmodule
`default_nettype wire

// ===== sv/swtm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module swtm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("invalid nonzero average");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[16]) else $error("valid with error");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second accept");
endmodule
bind sliding_window_trimmed_mean_core swtm_checker u_chk (.*);
`default_nettype wire
